// ===== rtl/core/pat_pkg.sv =====
`timescale 1ns / 1ps

package pat_pkg;

  // Default table depth
  localparam int unsigned DEPTH = 32;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIORITY    = 1'b1;

  // Configuration reset values
  localparam logic [TIME_W-1:0] THRESHOLD_RST    = 32'd30;
  localparam logic [PRIO_W-1:0] MAX_PRIORITY_RST = 2'd2;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_SET_WAIT   = 2'd2,
    OP_TICK       = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK      = 2'd0,
    KIND_PROMOTED = 2'd1,
    KIND_DONE     = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST_RD,
    ST_MOVE,
    ST_PROMOTE,
    ST_ACK,
    ST_DONE
  } state_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              waiting;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/pat_ram.sv =====
`timescale 1ns / 1ps

module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/priority_aging_table.sv =====
// A register request moves to the acknowledge state, which loads its result into the output
// register. Unregister and set waiting search one slot a cycle; unregister then reads the
// last entry and moves it into the freed slot. Aging tick walks one slot a cycle through the
// entry memory read port, pausing to promote each stale entry and while out_stall holds the
// output; one request at a time. Output waits on out_stall without losing results. Reset
// (rst_n, synchronous) empties the table and loads threshold 30 and max priority 2.
`timescale 1ns / 1ps

module priority_aging_table #(
  parameter int unsigned DEPTH = pat_pkg::DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [pat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pat_pkg::CFG_W-1:0]       cfg_wdata,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [pat_pkg::ID_W-1:0]        in_entry_id,
  input  logic [pat_pkg::PRIO_W-1:0]      in_start_priority,
  input  logic                            in_waiting_in,
  input  logic [pat_pkg::TIME_W-1:0]      in_now,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pat_pkg::KIND_W-1:0]      out_kind,
  output logic [pat_pkg::ID_W-1:0]        out_id,
  output logic [pat_pkg::PRIO_W-1:0]      out_new_priority,
  output logic [pat_pkg::STAT_W-1:0]      out_status,
  output logic                            out_last
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  // Configuration registers
  logic [pat_pkg::TIME_W-1:0] thresh_r;
  logic [pat_pkg::PRIO_W-1:0] maxp_r;

  // Control state
  pat_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]   found_idx_r, found_idx_nxt;
  pat_pkg::status_t status_r, status_nxt;

  // Captured request
  pat_pkg::opcode_t            op_r;
  logic [pat_pkg::ID_W-1:0]    id_r;
  logic                        wt_r;
  logic [pat_pkg::TIME_W-1:0]  now_r;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  pat_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [pat_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic [pat_pkg::PRIO_W-1:0]  out_prio_r, out_prio_nxt;
  pat_pkg::status_t            out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;

  // Memory port
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  pat_pkg::entry_t             ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [pat_pkg::ENTRY_W-1:0] ram_rdata;
  pat_pkg::entry_t             rd_ent;

  logic                        in_accept;
  logic                        out_free;
  logic                        full;
  logic [CW-1:0]               last_slot;
  logic [pat_pkg::TIME_W-1:0]  age;
  logic                        id_hit;
  logic                        tick_hit;
  logic                        hit;
  logic                        scan_end;
  logic [pat_pkg::PRIO_W-1:0]  prio_inc;

  pat_ram #(
    .WIDTH (pat_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and entry decode
  assign in_stall  = (state_r != pat_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (count_r >= CW'(DEPTH));
  assign last_slot = count_r - CW'(1);

  assign rd_ent   = pat_pkg::entry_t'(ram_rdata);
  assign age      = now_r - rd_ent.stamp;
  assign prio_inc = rd_ent.prio + pat_pkg::PRIO_W'(1);
  assign id_hit   = (rd_ent.id == id_r);
  assign tick_hit = rd_ent.waiting && (rd_ent.prio < maxp_r) && (age > thresh_r);
  assign hit      = chk_vld_r && ((op_r == pat_pkg::OP_TICK) ? tick_hit : id_hit);
  assign scan_end = !hit && (rd_idx_r >= count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pat_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (pat_pkg::opcode_t'(in_opcode) == pat_pkg::OP_REGISTER) begin
            state_nxt = pat_pkg::ST_ACK;
          end else begin
            state_nxt = pat_pkg::ST_SCAN;
          end
        end
      end
      pat_pkg::ST_SCAN: begin
        if (hit) begin
          unique case (op_r)
            pat_pkg::OP_UNREGISTER: state_nxt = pat_pkg::ST_LAST_RD;
            pat_pkg::OP_TICK:       state_nxt = pat_pkg::ST_PROMOTE;
            default:                state_nxt = pat_pkg::ST_ACK;
          endcase
        end else if (scan_end) begin
          if (op_r == pat_pkg::OP_TICK) begin
            state_nxt = pat_pkg::ST_DONE;
          end else begin
            state_nxt = pat_pkg::ST_ACK;
          end
        end
      end
      pat_pkg::ST_LAST_RD: state_nxt = pat_pkg::ST_MOVE;
      pat_pkg::ST_MOVE:    state_nxt = pat_pkg::ST_ACK;
      pat_pkg::ST_PROMOTE: begin
        if (out_free) begin
          state_nxt = pat_pkg::ST_SCAN;
        end
      end
      pat_pkg::ST_ACK, pat_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pat_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses, counters and result loads
  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    found_idx_nxt = found_idx_r;
    status_nxt    = status_r;

    ram_we    = 1'b0;
    ram_waddr = found_idx_r;
    ram_wdata = rd_ent;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r[IW-1:0];

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      pat_pkg::ST_IDLE: begin
        rd_idx_nxt  = '0;
        chk_vld_nxt = 1'b0;
        // Append on register, or report the table full
        if (in_accept && (pat_pkg::opcode_t'(in_opcode) == pat_pkg::OP_REGISTER)) begin
          if (full) begin
            status_nxt = pat_pkg::STAT_FULL;
          end else begin
            status_nxt        = pat_pkg::STAT_OK;
            ram_we            = 1'b1;
            ram_waddr         = count_r[IW-1:0];
            ram_wdata.id      = in_entry_id;
            ram_wdata.prio    = in_start_priority;
            ram_wdata.waiting = in_waiting_in;
            ram_wdata.stamp   = in_now;
            count_nxt         = count_r + CW'(1);
          end
        end
      end
      pat_pkg::ST_SCAN: begin
        if (hit) begin
          // Stop the walk on the matching slot
          chk_vld_nxt   = 1'b0;
          found_idx_nxt = chk_idx_r;
          status_nxt    = pat_pkg::STAT_OK;
          if (op_r == pat_pkg::OP_SET_WAIT) begin
            ram_we            = 1'b1;
            ram_waddr         = chk_idx_r;
            ram_wdata.waiting = wt_r;
          end
        end else if (rd_idx_r < count_r) begin
          // Issue the next slot read
          ram_re      = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          status_nxt  = pat_pkg::STAT_NOT_FOUND;
        end
      end
      pat_pkg::ST_LAST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = last_slot[IW-1:0];
      end
      pat_pkg::ST_MOVE: begin
        // Move the last entry into the freed slot
        ram_we    = 1'b1;
        ram_waddr = found_idx_r;
        count_nxt = last_slot;
      end
      pat_pkg::ST_PROMOTE: begin
        if (out_free) begin
          ram_we          = 1'b1;
          ram_waddr       = found_idx_r;
          ram_wdata.prio  = prio_inc;
          ram_wdata.stamp = now_r;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = pat_pkg::KIND_PROMOTED;
          out_id_nxt      = rd_ent.id;
          out_prio_nxt    = prio_inc;
          out_status_nxt  = pat_pkg::STAT_OK;
          out_last_nxt    = 1'b0;
        end
      end
      pat_pkg::ST_ACK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pat_pkg::KIND_ACK;
          out_id_nxt     = id_r;
          out_prio_nxt   = '0;
          out_status_nxt = status_r;
          out_last_nxt   = 1'b1;
        end
      end
      pat_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pat_pkg::KIND_DONE;
          out_id_nxt     = '0;
          out_prio_nxt   = '0;
          out_status_nxt = pat_pkg::STAT_OK;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        chk_vld_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pat_pkg::ST_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= pat_pkg::THRESHOLD_RST;
      maxp_r   <= pat_pkg::MAX_PRIORITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pat_pkg::CFG_AGING_THRESHOLD: thresh_r <= cfg_wdata;
        pat_pkg::CFG_MAX_PRIORITY:    maxp_r   <= cfg_wdata[pat_pkg::PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture and walk payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= pat_pkg::opcode_t'(in_opcode);
      id_r  <= in_entry_id;
      wt_r  <= in_waiting_in;
      now_r <= in_now;
    end
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_idx_r  <= found_idx_nxt;
    status_r     <= status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_id           = out_id_r;
  assign out_new_priority = out_prio_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pat_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int LONG_HOLD   = 200;

  // One result of the table, as seen on the out_ channel
  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    status_t           status;
    logic              last;
  } table_event_t;

  // One request, with an optional hand-written acknowledge or done
  typedef struct {
    opcode_t           op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] sp;
    logic              wt;
    logic [TIME_W-1:0] now;
    bit                lit;
    kind_t             lit_kind;
    logic [ID_W-1:0]   lit_id;
    status_t           lit_status;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_opcode;
  logic [ID_W-1:0]      in_entry_id;
  logic [PRIO_W-1:0]    in_start_priority;
  logic                 in_waiting_in;
  logic [TIME_W-1:0]    in_now;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    out_kind;
  logic [ID_W-1:0]      out_id;
  logic [PRIO_W-1:0]    out_new_priority;
  logic [STAT_W-1:0]    out_status;
  logic                 out_last;

  // Literal answer that travels with the request on the wire
  bit                   ack_literal;
  table_event_t         ack_literal_event;

  // Shadow copy of the table and its settings
  logic [ID_W-1:0]      tbl_ids[DEPTH];
  logic [PRIO_W-1:0]    tbl_prio[DEPTH];
  logic                 tbl_waiting[DEPTH];
  logic [TIME_W-1:0]    tbl_stamp[DEPTH];
  int                   tbl_count;
  logic [TIME_W-1:0]    aging_limit;
  logic [PRIO_W-1:0]    prio_ceiling;

  table_event_t         results_due[$];
  table_event_t         new_results[$];
  int                   fail_count;
  int                   stuck_cycles;
  bit                   sender_quiet;
  bit                   receiver_quiet;
  bit                   hold_off_pending;

  stim_row_t directed_rows[16] = '{
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'h0000_0000, 1'b1, KIND_DONE, 16'h0000, STAT_OK},
    '{OP_UNREGISTER, 16'h0005, 2'd0, 1'b0, 32'h0000_0000, 1'b1, KIND_ACK, 16'h0005,
      STAT_NOT_FOUND},
    '{OP_SET_WAIT,   16'hFFFF, 2'd3, 1'b1, 32'h0000_0000, 1'b1, KIND_ACK, 16'hFFFF,
      STAT_NOT_FOUND},
    '{OP_REGISTER,   16'hFFFF, 2'd0, 1'b1, 32'h0000_0000, 1'b1, KIND_ACK, 16'hFFFF, STAT_OK},
    '{OP_REGISTER,   16'h0000, 2'd3, 1'b1, 32'h0000_0000, 1'b1, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_REGISTER,   16'h0007, 2'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, KIND_ACK, 16'h0007, STAT_OK},
    '{OP_REGISTER,   16'h0007, 2'd0, 1'b1, 32'h0000_0064, 1'b1, KIND_ACK, 16'h0007, STAT_OK},
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'h0000_001E, 1'b0, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'h0000_001F, 1'b0, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_SET_WAIT,   16'h0007, 2'd0, 1'b1, 32'h0000_0000, 1'b1, KIND_ACK, 16'h0007, STAT_OK},
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_UNREGISTER, 16'h0007, 2'd0, 1'b0, 32'h0000_0000, 1'b1, KIND_ACK, 16'h0007, STAT_OK},
    '{OP_UNREGISTER, 16'hFFFF, 2'd0, 1'b0, 32'h0000_0000, 1'b1, KIND_ACK, 16'hFFFF, STAT_OK},
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'h8000_0000, 1'b0, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_SET_WAIT,   16'h0000, 2'd0, 1'b0, 32'h0000_0000, 1'b1, KIND_ACK, 16'h0000, STAT_OK},
    '{OP_TICK,       16'h0000, 2'd0, 1'b0, 32'h7FFF_FFFF, 1'b0, KIND_ACK, 16'h0000, STAT_OK}
  };

  priority_aging_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_entry_id      (in_entry_id),
    .in_start_priority(in_start_priority),
    .in_waiting_in    (in_waiting_in),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_id           (out_id),
    .out_new_priority (out_new_priority),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic table_event_t make_event(kind_t k, logic [ID_W-1:0] id,
                                              logic [PRIO_W-1:0] p, status_t s, logic l);
    table_event_t e;
    e.kind   = k;
    e.id     = id;
    e.prio   = p;
    e.status = s;
    e.last   = l;
    return e;
  endfunction

  // Update the shadow table with one request and queue the results it causes
  function automatic void apply_request(opcode_t op, logic [ID_W-1:0] id,
                                        logic [PRIO_W-1:0] sp, logic wt,
                                        logic [TIME_W-1:0] now);
    int slot;
    logic [TIME_W-1:0] age;
    new_results.delete();
    case (op)
      OP_REGISTER: begin
        if (tbl_count >= DEPTH) begin
          new_results.push_back(make_event(KIND_ACK, id, 2'd0, STAT_FULL, 1'b1));
        end else begin
          tbl_ids[tbl_count]     = id;
          tbl_prio[tbl_count]    = sp;
          tbl_waiting[tbl_count] = wt;
          tbl_stamp[tbl_count]   = now;
          tbl_count++;
          new_results.push_back(make_event(KIND_ACK, id, 2'd0, STAT_OK, 1'b1));
        end
      end
      OP_UNREGISTER, OP_SET_WAIT: begin
        // lowest slot holding the id wins
        slot = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (slot < 0 && tbl_ids[i] == id) slot = i;
        end
        if (slot < 0) begin
          new_results.push_back(make_event(KIND_ACK, id, 2'd0, STAT_NOT_FOUND, 1'b1));
        end else begin
          if (op == OP_UNREGISTER) begin
            tbl_ids[slot]     = tbl_ids[tbl_count-1];
            tbl_prio[slot]    = tbl_prio[tbl_count-1];
            tbl_waiting[slot] = tbl_waiting[tbl_count-1];
            tbl_stamp[slot]   = tbl_stamp[tbl_count-1];
            tbl_count--;
          end else begin
            tbl_waiting[slot] = wt;
          end
          new_results.push_back(make_event(KIND_ACK, id, 2'd0, STAT_OK, 1'b1));
        end
      end
      default: begin
        // walk the table, promote stale waiting entries, then close the tick
        for (int i = 0; i < tbl_count; i++) begin
          age = now - tbl_stamp[i];
          if (tbl_waiting[i] && tbl_prio[i] < prio_ceiling && age > aging_limit) begin
            tbl_prio[i]  = tbl_prio[i] + 2'd1;
            tbl_stamp[i] = now;
            new_results.push_back(make_event(KIND_PROMOTED, tbl_ids[i], tbl_prio[i],
                                             STAT_OK, 1'b0));
          end
        end
        new_results.push_back(make_event(KIND_DONE, 16'h0000, 2'd0, STAT_OK, 1'b1));
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin : scoreboard
    table_event_t want;
    if (rst_n && in_valid && !in_stall) begin
      apply_request(opcode_t'(in_opcode), in_entry_id, in_start_priority, in_waiting_in,
                    in_now);
      if (ack_literal) begin
        results_due.push_back(ack_literal_event);
      end else begin
        foreach (new_results[k]) results_due.push_back(new_results[k]);
      end
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d id %0h", out_kind, out_id);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("out_id", 32'(want.id), 32'(out_id));
        check_field("new_priority", 32'(want.prio), 32'(out_new_priority));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: stall a random, long or zero time before taking each result
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      if (hold_off_pending) begin
        hold = LONG_HOLD;
        hold_off_pending = 1'b0;
      end else begin
        hold = receiver_quiet ? 0 : $urandom_range(0, 11);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  // Offer one request after a random gap (none while sender_quiet) and hold it until taken
  task automatic send_request(stim_row_t r);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_opcode         <= r.op;
    in_entry_id       <= r.id;
    in_start_priority <= r.sp;
    in_waiting_in     <= r.wt;
    in_now            <= r.now;
    ack_literal       <= r.lit;
    ack_literal_event <= make_event(r.lit_kind, r.lit_id, 2'd0, r.lit_status, 1'b1);
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AGING_THRESHOLD) aging_limit = value;
    else prio_ceiling = value[PRIO_W-1:0];
  endtask

  function automatic stim_row_t plain_row(opcode_t op, logic [ID_W-1:0] id,
                                          logic [PRIO_W-1:0] sp, logic wt,
                                          logic [TIME_W-1:0] now);
    stim_row_t r;
    r.op         = op;
    r.id         = id;
    r.sp         = sp;
    r.wt         = wt;
    r.now        = now;
    r.lit        = 1'b0;
    r.lit_kind   = KIND_ACK;
    r.lit_id     = '0;
    r.lit_status = STAT_OK;
    return r;
  endfunction

  // Random mix over a small id pool so ids collide and entries age
  task automatic run_traffic(int count);
    logic [ID_W-1:0]   pool[8];
    logic [TIME_W-1:0] tnow;
    logic [ID_W-1:0]   id;
    opcode_t           op;
    int                pick;
    foreach (pool[k]) pool[k] = ID_W'($urandom());
    tnow = $urandom();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) tnow = $urandom();
      else tnow = tnow + $urandom_range(0, 12);
      id = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 7)] : ID_W'($urandom());
      if (pick < 35) begin
        op = OP_REGISTER;
      end else if (pick < 72) begin
        op = (pick < 55) ? OP_UNREGISTER : OP_SET_WAIT;
        if (tbl_count > 0 && $urandom_range(0, 9) < 7)
          id = tbl_ids[$urandom_range(0, tbl_count - 1)];
      end else begin
        op = OP_TICK;
      end
      send_request(plain_row(op, id, PRIO_W'($urandom_range(0, 3)),
                             $urandom_range(0, 9) < 7, tnow));
    end
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] t0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_opcode         = '0;
    in_entry_id       = '0;
    in_start_priority = '0;
    in_waiting_in     = 1'b0;
    in_now            = '0;
    ack_literal       = 1'b0;
    ack_literal_event = '0;
    tbl_count         = 0;
    aging_limit       = THRESHOLD_RST;
    prio_ceiling      = MAX_PRIORITY_RST;
    fail_count        = 0;
    stuck_cycles      = 0;
    sender_quiet      = 1'b0;
    receiver_quiet    = 1'b0;
    hold_off_pending  = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows under reset settings
    foreach (directed_rows[k]) send_request(directed_rows[k]);
    settle();

    // fill past full, promote every entry at once, then drain
    write_config(CFG_AGING_THRESHOLD, 32'd0);
    write_config(CFG_MAX_PRIORITY, 32'd3);
    t0 = $urandom();
    repeat (DEPTH + 2) send_request(plain_row(OP_REGISTER, ID_W'($urandom()), 2'd0, 1'b1, t0));
    send_request(plain_row(OP_TICK, 16'h0000, 2'd0, 1'b0, t0 + 5));
    send_request(plain_row(OP_TICK, 16'h0000, 2'd0, 1'b0, t0 + 5));
    send_request(plain_row(OP_TICK, 16'h0000, 2'd0, 1'b0, t0 + 6));
    while (tbl_count > 0)
      send_request(plain_row(OP_UNREGISTER, tbl_ids[$urandom_range(0, tbl_count - 1)],
                             2'd0, 1'b0, t0));
    settle();

    // nothing can ever age
    write_config(CFG_AGING_THRESHOLD, 32'hFFFF_FFFF);
    write_config(CFG_MAX_PRIORITY, 32'd0);
    run_traffic(50);
    settle();

    write_config(CFG_AGING_THRESHOLD, 32'd20);
    write_config(CFG_MAX_PRIORITY, 32'd3);
    run_traffic(70);
    settle();

    // hold the result side off while requests keep coming
    write_config(CFG_AGING_THRESHOLD, 32'($urandom_range(0, 40)));
    write_config(CFG_MAX_PRIORITY, 32'd1);
    hold_off_pending = 1'b1;
    sender_quiet     = 1'b1;
    run_traffic(60);
    sender_quiet     = 1'b0;
    settle();

    // back-to-back stretch on both sides
    write_config(CFG_AGING_THRESHOLD, 32'd10);
    write_config(CFG_MAX_PRIORITY, 32'd2);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_traffic(60);
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
